### src/int64_alu_floor_divide_defines.svh
// ---------------------------------------------------------------------------
// int64_alu_floor_divide assertion macros
// Shared concurrent assertion shorthands for the ALU.
// ---------------------------------------------------------------------------
`ifndef INT64_ALU_FLOOR_DIVIDE_DEFINES_SVH
`define INT64_ALU_FLOOR_DIVIDE_DEFINES_SVH

// prop must hold at every clock edge out of reset
`define IFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true out of reset
`define IFD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/ifd_pkg.sv
// ---------------------------------------------------------------------------
// ifd_pkg
// Types and constants shared by the floor-divide ALU modules.
// ---------------------------------------------------------------------------
package ifd_pkg;

    localparam int XLEN           = 64;
    localparam int DATA_WIDTH_DEF = 64;

    // operation codes on the action field
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;

    // class assigned by the front end
    typedef enum logic [2:0] {
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_MOD,
        K_DZ,   // divide or modulo by zero
        K_NOP   // undefined opcode
    } t_kind;

    typedef struct packed {
        logic [2:0]      action;
        logic [XLEN-1:0] lhs;
        logic [XLEN-1:0] rhs;
    } t_req;

    typedef struct packed {
        logic [XLEN-1:0] result;
        logic            status;
    } t_rsp;

    // classified transaction: a/b are raw operands for add/sub/mul,
    // magnitudes for divide and modulo
    typedef struct packed {
        t_kind           kind;
        logic            neg_n;
        logic            neg_d;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
    } t_cls;

endpackage

### src/int64_alu_floor_divide.sv
// ---------------------------------------------------------------------------
// int64_alu_floor_divide
// Signed ALU: wrapping add, subtract, multiply, floored divide and modulo.
// ---------------------------------------------------------------------------
// Takes one transaction per cycle and returns one result per transaction, in
// order. A transaction passes through the front queue, DATA_WIDTH stages of
// the divide pipeline (one quotient bit per stage, the split multiplier
// riding in the first two), one sign fix-up stage and the output register.
// Every operation travels the full pipeline so results leave in order. Only
// the low DATA_WIDTH bits of each operand are used, read as two's complement;
// results come back sign-extended to 64 bits. Divide rounds toward negative
// infinity, modulo takes the sign of the divisor. A zero divisor gives result
// 0 with status 1; the minimum value divided by -1 wraps to itself, its
// modulo is 0; undefined opcodes give 0 with status 0. When the result side
// stalls the pipeline freezes and the two-entry front queue absorbs new
// requests until full rises.
// ---------------------------------------------------------------------------
`include "int64_alu_floor_divide_defines.svh"

module int64_alu_floor_divide #(
    parameter int DATA_WIDTH = ifd_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  ifd_pkg::t_req i_req,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output ifd_pkg::t_rsp o_rsp
);

    logic          q_vld;
    ifd_pkg::t_cls q_cls;
    logic          take;
    logic          hold;
    logic          b_vld;
    ifd_pkg::t_rsp b_rsp;
    logic          load;
    logic          r_full;
    ifd_pkg::t_rsp r_rsp;

    // front end: classify and queue
    ifd_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (i_req),
        .o_full  (full),
        .o_vld   (q_vld),
        .o_cls   (q_cls),
        .i_take  (take)
    );

    // back end: execution pipeline
    ifd_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_cls   (q_cls),
        .o_take  (take),
        .i_hold  (hold),
        .o_vld   (b_vld),
        .o_rsp   (b_rsp)
    );

    // output register; freed in the same cycle it is popped
    assign hold = r_full && !pop;
    assign load = b_vld && !hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (load) begin
            r_full <= 1'b1;
        end else if (pop) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rsp <= b_rsp;
        end
    end

    assign empty = !r_full;
    assign o_rsp = r_rsp;

    // a waiting result is never overwritten
    `IFD_NEVER(a_no_overwrite, i_clk, i_rst_n, load && r_full && !pop, "result overwritten")
    // zero-division results carry value 0
    `IFD_NEVER(a_dz_zero, i_clk, i_rst_n, r_full && r_rsp.status && (r_rsp.result != '0),
               "nonzero result on zero division")
    // a stalled pipeline output stays put
    `IFD_ASSERT(a_stall_keep, i_clk, i_rst_n, (b_vld && hold) |=> b_vld, "stalled result lost")

endmodule

### src/ifd_front.sv
// ---------------------------------------------------------------------------
// ifd_front
// Accepts requests, classifies them and buffers them in a two-entry queue.
// ---------------------------------------------------------------------------
module ifd_front #(
    parameter int DATA_WIDTH = ifd_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ifd_pkg::t_req i_req,
    output logic          o_full,
    output logic          o_vld,
    output ifd_pkg::t_cls o_cls,
    input  logic          i_take
);

    logic signed [DATA_WIDTH-1:0] lhs_w;
    logic signed [DATA_WIDTH-1:0] rhs_w;
    logic [ifd_pkg::XLEN-1:0]     lx;
    logic [ifd_pkg::XLEN-1:0]     rx;
    logic                         wr;
    logic                         rd;
    ifd_pkg::t_cls                n_cls;
    ifd_pkg::t_cls                r_q [2];
    logic                         r_wr;
    logic                         r_rd;
    logic [1:0]                   r_cnt;

    assign lhs_w = i_req.lhs[DATA_WIDTH-1:0];
    assign rhs_w = i_req.rhs[DATA_WIDTH-1:0];
    assign lx    = ifd_pkg::XLEN'(lhs_w);
    assign rx    = ifd_pkg::XLEN'(rhs_w);

    always_comb begin
        n_cls.neg_n = lx[ifd_pkg::XLEN-1];
        n_cls.neg_d = rx[ifd_pkg::XLEN-1];
        n_cls.a     = lx;
        n_cls.b     = rx;
        unique case (i_req.action)
            ifd_pkg::OP_ADD: n_cls.kind = ifd_pkg::K_ADD;
            ifd_pkg::OP_SUB: n_cls.kind = ifd_pkg::K_SUB;
            ifd_pkg::OP_MUL: n_cls.kind = ifd_pkg::K_MUL;
            ifd_pkg::OP_DIV, ifd_pkg::OP_MOD: begin
                if (rx == '0) begin
                    n_cls.kind = ifd_pkg::K_DZ;
                end else if (i_req.action == ifd_pkg::OP_DIV) begin
                    n_cls.kind = ifd_pkg::K_DIV;
                end else begin
                    n_cls.kind = ifd_pkg::K_MOD;
                end
                n_cls.a = n_cls.neg_n ? -lx : lx;
                n_cls.b = n_cls.neg_d ? -rx : rx;
            end
            default: n_cls.kind = ifd_pkg::K_NOP;
        endcase
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_cls  = r_q[r_rd];
    assign wr     = i_push && !o_full;
    assign rd     = i_take && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wr <= ~r_wr;
            end
            if (rd) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wr] <= n_cls;
        end
    end

endmodule

### src/ifd_back.sv
// ---------------------------------------------------------------------------
// ifd_back
// Execution pipeline: split multiplier in the first two stages, one restoring
// divide step per stage, then a sign fix-up stage.
// ---------------------------------------------------------------------------
module ifd_back #(
    parameter int DATA_WIDTH = ifd_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  ifd_pkg::t_cls i_cls,
    output logic          o_take,
    input  logic          i_hold,
    output logic          o_vld,
    output ifd_pkg::t_rsp o_rsp
);

    localparam int W = DATA_WIDTH;
    localparam int H = W / 2;
    localparam int L = W - H;

    typedef struct packed {
        ifd_pkg::t_kind kind;
        logic           nn;
        logic           nd;
        logic [W-1:0]   rem;
        logic [W-1:0]   dq;
        logic [W-1:0]   ad;
        logic [W-1:0]   res;
        logic [W-1:0]   plo;
        logic [L-1:0]   px;
    } t_st;

    logic         en;
    logic [W:0]   r_vld;
    t_st          r_st [W];
    t_st          src  [W];
    t_st          n_st [W];
    t_st          lst;
    logic [W-1:0] n_res;
    logic         n_sts;
    logic         rm_nz;
    logic         r_sts;
    logic [W-1:0] r_res;

    assign en     = !(r_vld[W] && i_hold);
    assign o_take = en;

    // stage 0 source comes straight from the queue
    always_comb begin
        src[0].kind = i_cls.kind;
        src[0].nn   = i_cls.neg_n;
        src[0].nd   = i_cls.neg_d;
        src[0].rem  = '0;
        src[0].dq   = i_cls.a[W-1:0];
        src[0].ad   = i_cls.b[W-1:0];
        src[0].plo  = '0;
        src[0].px   = '0;
        unique case (i_cls.kind)
            ifd_pkg::K_ADD: src[0].res = i_cls.a[W-1:0] + i_cls.b[W-1:0];
            ifd_pkg::K_SUB: src[0].res = i_cls.a[W-1:0] - i_cls.b[W-1:0];
            default:        src[0].res = '0;
        endcase
    end

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic [W:0] t;
        logic       ge;
        logic [W:0] diff;

        if (g > 0) begin : g_link
            assign src[g] = r_st[g-1];
        end

        assign t    = {src[g].rem, src[g].dq[W-1]};
        assign diff = t - {1'b0, src[g].ad};
        assign ge   = !diff[W];

        always_comb begin
            n_st[g]     = src[g];
            n_st[g].rem = ge ? diff[W-1:0] : t[W-1:0];
            n_st[g].dq  = {src[g].dq[W-2:0], ge};
            if (g == 0) begin
                n_st[g].plo = W'(src[g].dq[H-1:0] * src[g].ad[H-1:0]);
                n_st[g].px  = L'(src[g].dq[W-1:H] * src[g].ad[H-1:0])
                            + L'(src[g].dq[H-1:0] * src[g].ad[W-1:H]);
            end
            if (g == 1 && src[g].kind == ifd_pkg::K_MUL) begin
                n_st[g].res = src[g].plo + {src[g].px, {H{1'b0}}};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    // quotient magnitude in dq, remainder magnitude in rem
    assign lst   = r_st[W-1];
    assign rm_nz = (lst.rem != '0);

    always_comb begin
        n_sts = 1'b0;
        unique case (lst.kind)
            ifd_pkg::K_ADD, ifd_pkg::K_SUB, ifd_pkg::K_MUL: n_res = lst.res;
            ifd_pkg::K_DIV: begin
                if (lst.nn != lst.nd) begin
                    n_res = -lst.dq - W'(rm_nz);
                end else begin
                    n_res = lst.dq;
                end
            end
            ifd_pkg::K_MOD: begin
                if (lst.nn == lst.nd) begin
                    n_res = lst.nn ? -lst.rem : lst.rem;
                end else if (!rm_nz) begin
                    n_res = '0;
                end else begin
                    n_res = lst.nn ? lst.ad - lst.rem : lst.rem - lst.ad;
                end
            end
            ifd_pkg::K_DZ: begin
                n_res = '0;
                n_sts = 1'b1;
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[W-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_sts <= n_sts;
        end
    end

    assign o_vld        = r_vld[W];
    assign o_rsp.result = ifd_pkg::XLEN'(signed'(r_res));
    assign o_rsp.status = r_sts;

endmodule
